/* rtl/rhr_pkg.sv */
`timescale 1ns / 1ps

package rhr_pkg;

  localparam logic [15:0] HueFull    = 16'd23040;
  localparam logic [15:0] HueFull2   = 16'd46080;
  localparam logic [14:0] HueGreen   = 15'd7680;
  localparam logic [14:0] HueBlue    = 15'd15360;
  localparam logic [19:0] NumMul     = 20'd3840;
  localparam logic [32:0] FracMul    = 33'd1118482;
  localparam int          DivStages  = 4;
  localparam int          DivPer     = 3;
  localparam int          QuoW       = DivStages * DivPer;

  typedef enum logic [1:0] {
    BASE_RED,
    BASE_GREEN,
    BASE_BLUE
  } base_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0]      mn;
    logic [7:0]      delta;
    logic [7:0]      alpha;
    logic [7:0]      rem;
    logic [QuoW-1:0] num_lo;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            zero;
    base_e           base;
  } div_t;

  typedef struct packed {
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [7:0]  alpha;
    logic [2:0]  sector;
    logic [11:0] rem;
  } sec_t;

endpackage

/* rtl/rhr_in_if.sv */
`timescale 1ns / 1ps

interface rhr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

/* rtl/rhr_out_if.sv */
`timescale 1ns / 1ps

interface rhr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

/* rtl/rgb_hue_rotate_core.sv */
`timescale 1ns / 1ps

// Hue rotation of RGBA8 pixels: each pixel goes to HSV, its hue is advanced by
// cfg_data_i (1/64 degree units, 23040 = 360 degrees) and it comes back to RGB;
// alpha passes through. One pixel is accepted per clock unless backpressure
// stalls the ten-stage pipeline, of which four stages are the restoring divider
// that forms the hue offset, three bits per stage. Every stage holds under
// backpressure and accepts a new request whenever it or a later stage is empty.
// Write the shift register only while the pipeline is empty.

module rgb_hue_rotate_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  rhr_in_if.sink       pix_i,
  rhr_out_if.source    pix_o,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_data_i
);

  logic [14:0]     shift_q;
  rhr_pkg::pixel_t in_pix, out_pix;
  rhr_pkg::div_t   hsv_data, div_data;
  rhr_pkg::sec_t   sec_data;
  logic            hsv_v, hsv_r, div_v, div_r, sec_v, sec_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_we_i) begin
      shift_q <= cfg_data_i;
    end
  end

  assign in_pix.red = pix_i.red_in;
  assign in_pix.green = pix_i.green_in;
  assign in_pix.blue = pix_i.blue_in;
  assign in_pix.alpha = pix_i.alpha_in;

  rhr_hsv u_hsv (
    .clk_i, .rst_ni,
    .in_valid_i (pix_i.valid), .in_pix_i (in_pix), .in_ready_o (pix_i.ready),
    .out_valid_o (hsv_v), .out_data_o (hsv_data), .out_ready_i (hsv_r)
  );

  rhr_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i (hsv_v), .in_data_i (hsv_data), .in_ready_o (hsv_r),
    .out_valid_o (div_v), .out_data_o (div_data), .out_ready_i (div_r)
  );

  rhr_hue u_hue (
    .clk_i, .rst_ni, .hue_shift_i (shift_q),
    .in_valid_i (div_v), .in_data_i (div_data), .in_ready_o (div_r),
    .out_valid_o (sec_v), .out_data_o (sec_data), .out_ready_i (sec_r)
  );

  rhr_rgb u_rgb (
    .clk_i, .rst_ni,
    .in_valid_i (sec_v), .in_data_i (sec_data), .in_ready_o (sec_r),
    .out_valid_o (pix_o.valid), .out_pix_o (out_pix), .out_ready_i (pix_o.ready)
  );

  assign pix_o.red_out = out_pix.red;
  assign pix_o.green_out = out_pix.green;
  assign pix_o.blue_out = out_pix.blue;
  assign pix_o.alpha_out = out_pix.alpha;

endmodule

/* rtl/rhr_hsv.sv */
`timescale 1ns / 1ps

module rhr_hsv (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rhr_pkg::pixel_t in_pix_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output rhr_pkg::div_t out_data_o,
  input  logic          out_ready_i
);

  logic          valid_q;
  rhr_pkg::div_t data_q, data_d;
  logic [7:0]    mx, mn, op_a, op_b, dabs;
  logic [19:0]   num;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    mx = (in_pix_i.red > in_pix_i.green) ? in_pix_i.red : in_pix_i.green;
    mx = (mx > in_pix_i.blue) ? mx : in_pix_i.blue;
    mn = (in_pix_i.red < in_pix_i.green) ? in_pix_i.red : in_pix_i.green;
    mn = (mn < in_pix_i.blue) ? mn : in_pix_i.blue;
    priority if (mx == in_pix_i.red) begin
      data_d.base = rhr_pkg::BASE_RED;
      op_a = in_pix_i.green;
      op_b = in_pix_i.blue;
    end else if (mx == in_pix_i.green) begin
      data_d.base = rhr_pkg::BASE_GREEN;
      op_a = in_pix_i.blue;
      op_b = in_pix_i.red;
    end else begin
      data_d.base = rhr_pkg::BASE_BLUE;
      op_a = in_pix_i.red;
      op_b = in_pix_i.green;
    end
    data_d.neg = op_a < op_b;
    dabs = data_d.neg ? (op_b - op_a) : (op_a - op_b);
    num = 20'(dabs) * rhr_pkg::NumMul;
    data_d.mn = mn;
    data_d.delta = mx - mn;
    data_d.alpha = in_pix_i.alpha;
    data_d.zero = (mx == mn);
    data_d.rem = num[19:rhr_pkg::QuoW];
    data_d.num_lo = num[rhr_pkg::QuoW-1:0];
    data_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

/* rtl/rhr_div.sv */
`timescale 1ns / 1ps

module rhr_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rhr_pkg::div_t in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output rhr_pkg::div_t out_data_o,
  input  logic          out_ready_i
);

  localparam int N = rhr_pkg::DivStages;

  logic [N-1:0]  valid_q;
  logic [N-1:0]  rdy;
  logic [N-1:0]  src_v;
  rhr_pkg::div_t data_q [N];
  rhr_pkg::div_t data_d [N];

  function automatic rhr_pkg::div_t div_step(rhr_pkg::div_t x);
    rhr_pkg::div_t y;
    logic [8:0]    r9;
    y = x;
    for (int i = 0; i < rhr_pkg::DivPer; i++) begin
      r9 = {y.rem, y.num_lo[rhr_pkg::QuoW-1]};
      y.num_lo = {y.num_lo[rhr_pkg::QuoW-2:0], 1'b0};
      if (r9 >= {1'b0, y.delta}) begin
        r9 = r9 - {1'b0, y.delta};
        y.quo = {y.quo[rhr_pkg::QuoW-2:0], 1'b1};
      end else begin
        y.quo = {y.quo[rhr_pkg::QuoW-2:0], 1'b0};
      end
      y.rem = r9[7:0];
    end
    return y;
  endfunction

  always_comb begin
    for (int k = N - 1; k >= 0; k--) begin
      if (k == N - 1) begin
        rdy[k] = !valid_q[k] || out_ready_i;
      end else begin
        rdy[k] = !valid_q[k] || rdy[k+1];
      end
    end
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        src_v[k] = in_valid_i;
        data_d[k] = div_step(in_data_i);
      end else begin
        src_v[k] = valid_q[k-1];
        data_d[k] = div_step(data_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= src_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        data_q[k] <= data_d[k];
      end
    end
  end

  assign in_ready_o = rdy[0];
  assign out_valid_o = valid_q[N-1];
  assign out_data_o = data_q[N-1];

endmodule

/* rtl/rhr_hue.sv */
`timescale 1ns / 1ps

module rhr_hue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [14:0]   hue_shift_i,
  input  logic          in_valid_i,
  input  rhr_pkg::div_t in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output rhr_pkg::sec_t out_data_o,
  input  logic          out_ready_i
);

  logic          va_q, vb_q, rdy_a, rdy_b;
  logic [7:0]    mn_q, delta_q, alpha_q;
  logic [14:0]   h2_q, h2_d, hue;
  logic [15:0]   sum;
  logic [14:0]   q15;
  rhr_pkg::sec_t sec_q, sec_d;
  logic [14:0]   sbase;

  assign rdy_b = !vb_q || out_ready_i;
  assign rdy_a = !va_q || rdy_b;

  always_comb begin
    q15 = 15'(in_data_i.quo);
    unique case (in_data_i.base)
      rhr_pkg::BASE_RED:   hue = in_data_i.neg ? (15'(rhr_pkg::HueFull) - q15) : q15;
      rhr_pkg::BASE_GREEN: hue = in_data_i.neg ? (rhr_pkg::HueGreen - q15)
                                               : (rhr_pkg::HueGreen + q15);
      rhr_pkg::BASE_BLUE:  hue = in_data_i.neg ? (rhr_pkg::HueBlue - q15)
                                               : (rhr_pkg::HueBlue + q15);
      default:             hue = '0;
    endcase
    if (in_data_i.zero) begin
      hue = '0;
    end
    sum = 16'(hue) + 16'(hue_shift_i);
    priority if (sum >= rhr_pkg::HueFull2) begin
      h2_d = 15'(sum - rhr_pkg::HueFull2);
    end else if (sum >= rhr_pkg::HueFull) begin
      h2_d = 15'(sum - rhr_pkg::HueFull);
    end else begin
      h2_d = sum[14:0];
    end
  end

  always_comb begin
    priority if (h2_q >= 15'd19200) begin
      sec_d.sector = 3'd5;
      sbase = 15'd19200;
    end else if (h2_q >= 15'd15360) begin
      sec_d.sector = 3'd4;
      sbase = 15'd15360;
    end else if (h2_q >= 15'd11520) begin
      sec_d.sector = 3'd3;
      sbase = 15'd11520;
    end else if (h2_q >= 15'd7680) begin
      sec_d.sector = 3'd2;
      sbase = 15'd7680;
    end else if (h2_q >= 15'd3840) begin
      sec_d.sector = 3'd1;
      sbase = 15'd3840;
    end else begin
      sec_d.sector = 3'd0;
      sbase = 15'd0;
    end
    sec_d.rem = 12'(h2_q - sbase);
    sec_d.mn = mn_q;
    sec_d.delta = delta_q;
    sec_d.alpha = alpha_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      h2_q <= h2_d;
      mn_q <= in_data_i.mn;
      delta_q <= in_data_i.delta;
      alpha_q <= in_data_i.alpha;
    end
    if (rdy_b) begin
      sec_q <= sec_d;
    end
  end

  assign in_ready_o = rdy_a;
  assign out_valid_o = vb_q;
  assign out_data_o = sec_q;

endmodule

/* rtl/rhr_rgb.sv */
`timescale 1ns / 1ps

module rhr_rgb (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rhr_pkg::sec_t  in_data_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output rhr_pkg::pixel_t out_pix_o,
  input  logic           out_ready_i
);

  logic            va_q, vb_q, vc_q, rdy_a, rdy_b, rdy_c;
  logic [15:0]     frac_q, frac_d;
  logic [32:0]     fprod;
  logic [2:0]      sec_a_q, sec_b_q;
  logic [7:0]      mn_a_q, mn_b_q, dl_a_q, dl_b_q, al_a_q, al_b_q;
  logic [16:0]     tval;
  logic [24:0]     xprod;
  logic [7:0]      x_q, x_d;
  logic [7:0]      cr, cg, cb;
  logic [8:0]      sr, sg, sb;
  rhr_pkg::pixel_t pix_q, pix_d;

  assign rdy_c = !vc_q || out_ready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  always_comb begin
    fprod = 33'(in_data_i.rem) * rhr_pkg::FracMul;
    frac_d = fprod[31:16];
  end

  always_comb begin
    tval = sec_a_q[0] ? (17'h10000 - 17'(frac_q)) : 17'(frac_q);
    xprod = 25'(dl_a_q) * 25'(tval);
    x_d = xprod[23:16];
  end

  always_comb begin
    unique case (sec_b_q)
      3'd0: begin
        cr = dl_b_q; cg = x_q; cb = '0;
      end
      3'd1: begin
        cr = x_q; cg = dl_b_q; cb = '0;
      end
      3'd2: begin
        cr = '0; cg = dl_b_q; cb = x_q;
      end
      3'd3: begin
        cr = '0; cg = x_q; cb = dl_b_q;
      end
      3'd4: begin
        cr = x_q; cg = '0; cb = dl_b_q;
      end
      default: begin
        cr = dl_b_q; cg = '0; cb = x_q;
      end
    endcase
    sr = 9'(cr) + 9'(mn_b_q);
    sg = 9'(cg) + 9'(mn_b_q);
    sb = 9'(cb) + 9'(mn_b_q);
    pix_d.red = sr[8] ? 8'hFF : sr[7:0];
    pix_d.green = sg[8] ? 8'hFF : sg[7:0];
    pix_d.blue = sb[8] ? 8'hFF : sb[7:0];
    pix_d.alpha = al_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      frac_q <= frac_d;
      sec_a_q <= in_data_i.sector;
      mn_a_q <= in_data_i.mn;
      dl_a_q <= in_data_i.delta;
      al_a_q <= in_data_i.alpha;
    end
    if (rdy_b) begin
      x_q <= x_d;
      sec_b_q <= sec_a_q;
      mn_b_q <= mn_a_q;
      dl_b_q <= dl_a_q;
      al_b_q <= al_a_q;
    end
    if (rdy_c) begin
      pix_q <= pix_d;
    end
  end

  assign in_ready_o = rdy_a;
  assign out_valid_o = vc_q;
  assign out_pix_o = pix_q;

endmodule
